// ===== design/xyb_pkg.sv =====
// shared constants, types and helper functions for the xyb to linear rgb converter
// used by every module of the block; depends on nothing else
package xyb_pkg;

  // sample format: signed q4.frac
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 4;
  localparam int COEF_FRAC    = 14;
  localparam int BIAS_FRAC    = 18;
  localparam int SCALE_FRAC   = 16;

  // register file geometry
  localparam int FIELD_W    = 20;
  localparam int REG_W      = 60;
  localparam int SCALE_W    = 24;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 3;

  // bias alignment from q2.18 to frac bits
  localparam int ALIGN_UP   = (FRAC_BITS >= BIAS_FRAC) ? FRAC_BITS - BIAS_FRAC : 0;
  localparam int ALIGN_DN   = (FRAC_BITS >= BIAS_FRAC) ? 0 : BIAS_FRAC - FRAC_BITS;
  localparam int ALIGN_HSH  = (ALIGN_DN > 0) ? ALIGN_DN - 1 : 0;
  localparam int ALIGN_W    = FIELD_W + 1 + ALIGN_UP;

  // datapath widths
  localparam int GRAW_W  = ((SAMPLE_WIDTH > ALIGN_W) ? SAMPLE_WIDTH : ALIGN_W) + 2;
  localparam int GAMMA_W = FRAC_BITS + 3;
  localparam int SQ_W    = FRAC_BITS + 6;
  localparam int CUBE_W  = FRAC_BITS + 8;
  localparam int V_W     = ((CUBE_W > ALIGN_W) ? CUBE_W : ALIGN_W) + 1;
  localparam int LMS_W   = FRAC_BITS + 14;
  localparam int PROD_W  = FIELD_W + LMS_W;
  localparam int ACC_W   = PROD_W + 2;

  // register stages from input register to output register
  localparam int PIPE_DEPTH = 7;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAT_RED   = 3'd0,
    REG_MAT_GREEN = 3'd1,
    REG_MAT_BLUE  = 3'd2,
    REG_BIAS      = 3'd3,
    REG_CBRT_BIAS = 3'd4,
    REG_SCALE     = 3'd5
  } xyb_reg_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [FIELD_W-1:0]      field_t;
  typedef logic signed [LMS_W-1:0]        lms_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0]   mat_red;
    logic [REG_W-1:0]   mat_green;
    logic [REG_W-1:0]   mat_blue;
    logic [REG_W-1:0]   bias;
    logic [REG_W-1:0]   cbrt;
    logic [SCALE_W-1:0] scale;
  } xyb_cfg_t;

  // signed 20-bit element k of a packed triplet
  function automatic field_t field20(logic [REG_W-1:0] r, int k);
    return field_t'(r[FIELD_W*k +: FIELD_W]);
  endfunction

  // q2.18 to frac bits, rounding half up when bits are dropped
  function automatic logic signed [ALIGN_W-1:0] align_bias(field_t v);
    logic signed [FIELD_W:0] rnd;
    rnd = $signed({v[FIELD_W-1], v}) + $signed((FIELD_W+1)'(1) << ALIGN_HSH);
    if (ALIGN_DN == 0) begin
      return ALIGN_W'(v) <<< ALIGN_UP;
    end else begin
      return ALIGN_W'(rnd >>> ALIGN_DN);
    end
  endfunction

endpackage

// ===== design/xyb_cfg.sv =====
// apb register file holding matrix rows, biases and intensity scale
// depends on xyb_pkg
module xyb_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [xyb_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [xyb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [xyb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output xyb_pkg::xyb_cfg_t                    cfg
);

  logic [xyb_pkg::REG_W-1:0]   mat_red;
  logic [xyb_pkg::REG_W-1:0]   mat_green;
  logic [xyb_pkg::REG_W-1:0]   mat_blue;
  logic [xyb_pkg::REG_W-1:0]   bias;
  logic [xyb_pkg::REG_W-1:0]   cbrt;
  logic [xyb_pkg::SCALE_W-1:0] scale;

  xyb_pkg::xyb_reg_t idx;
  logic              wr_en;

  assign idx    = xyb_pkg::xyb_reg_t'(paddr[xyb_pkg::APB_ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_red   <= '0;
      mat_green <= '0;
      mat_blue  <= '0;
      bias      <= '0;
      cbrt      <= '0;
      scale     <= xyb_pkg::SCALE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        xyb_pkg::REG_MAT_RED:   mat_red   <= pwdata[xyb_pkg::REG_W-1:0];
        xyb_pkg::REG_MAT_GREEN: mat_green <= pwdata[xyb_pkg::REG_W-1:0];
        xyb_pkg::REG_MAT_BLUE:  mat_blue  <= pwdata[xyb_pkg::REG_W-1:0];
        xyb_pkg::REG_BIAS:      bias      <= pwdata[xyb_pkg::REG_W-1:0];
        xyb_pkg::REG_CBRT_BIAS: cbrt      <= pwdata[xyb_pkg::REG_W-1:0];
        xyb_pkg::REG_SCALE:     scale     <= pwdata[xyb_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      xyb_pkg::REG_MAT_RED:   prdata = xyb_pkg::APB_DATA_W'(mat_red);
      xyb_pkg::REG_MAT_GREEN: prdata = xyb_pkg::APB_DATA_W'(mat_green);
      xyb_pkg::REG_MAT_BLUE:  prdata = xyb_pkg::APB_DATA_W'(mat_blue);
      xyb_pkg::REG_BIAS:      prdata = xyb_pkg::APB_DATA_W'(bias);
      xyb_pkg::REG_CBRT_BIAS: prdata = xyb_pkg::APB_DATA_W'(cbrt);
      xyb_pkg::REG_SCALE:     prdata = xyb_pkg::APB_DATA_W'(scale);
      default:                prdata = '0;
    endcase
  end

  assign cfg = '{mat_red:   mat_red,
                 mat_green: mat_green,
                 mat_blue:  mat_blue,
                 bias:      bias,
                 cbrt:      cbrt,
                 scale:     scale};

endmodule

// ===== design/xyb_lms.sv =====
// one lms channel: gamma clamp, square, cube plus bias, intensity scale
// four register stages sharing the pipeline advance; depends on xyb_pkg
module xyb_lms (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic signed [xyb_pkg::SAMPLE_WIDTH:0]  sum_in,
  input  xyb_pkg::field_t                        cbrt,
  input  xyb_pkg::field_t                        bias,
  input  logic [xyb_pkg::SCALE_W-1:0]            scale,
  output xyb_pkg::lms_t                          lms
);

  localparam int F     = xyb_pkg::FRAC_BITS;
  localparam int GR_W  = xyb_pkg::GRAW_W;
  localparam int G_W   = xyb_pkg::GAMMA_W;
  localparam int P2_W  = 2 * G_W;
  localparam int P3_W  = xyb_pkg::SQ_W + G_W;
  localparam int SC_W  = xyb_pkg::V_W + xyb_pkg::SCALE_W + 1;
  localparam logic signed [P2_W:0] SQ_HALF   = $signed((P2_W+1)'(1) << (F - 1));
  localparam logic signed [P3_W:0] CUBE_HALF = $signed((P3_W+1)'(1) << (F - 1));
  localparam logic signed [SC_W:0] SC_HALF   =
    $signed((SC_W+1)'(1) << (xyb_pkg::SCALE_FRAC - 1));

  // stage registers
  logic signed [G_W-1:0]             g1;
  logic signed [G_W-1:0]             g2;
  logic signed [xyb_pkg::SQ_W-1:0]   sq2;
  logic signed [xyb_pkg::V_W-1:0]    v3;

  logic signed [GR_W-1:0]            graw;
  logic                              g_fits;
  logic signed [G_W-1:0]             g_next;
  logic signed [P2_W-1:0]            prod_sq;
  logic signed [P2_W:0]              sq_rnd;
  logic signed [xyb_pkg::SQ_W-1:0]   sq_next;
  logic signed [P3_W-1:0]            prod_cube;
  logic signed [P3_W:0]              cube_rnd;
  logic signed [xyb_pkg::CUBE_W-1:0] cube;
  logic signed [xyb_pkg::V_W-1:0]    v_next;
  logic signed [SC_W-1:0]            prod_sc;
  logic signed [SC_W:0]              sc_rnd;
  logic signed [SC_W:0]              sc_sh;
  logic                              l_fits;
  xyb_pkg::lms_t                     lms_next;

  // gamma term minus cube root bias, clamped to [-4, 4)
  always_comb begin
    graw   = GR_W'(sum_in) - GR_W'(xyb_pkg::align_bias(cbrt));
    g_fits = (&graw[GR_W-1:G_W-1]) | ~(|graw[GR_W-1:G_W-1]);
    g_next = g_fits ? graw[G_W-1:0] : {graw[GR_W-1], {(G_W-1){~graw[GR_W-1]}}};
  end

  // square
  always_comb begin
    prod_sq = g1 * g1;
    sq_rnd  = (P2_W+1)'(prod_sq) + SQ_HALF;
    sq_next = xyb_pkg::SQ_W'(sq_rnd >>> F);
  end

  // cube and opsin bias
  always_comb begin
    prod_cube = sq2 * g2;
    cube_rnd  = (P3_W+1)'(prod_cube) + CUBE_HALF;
    cube      = xyb_pkg::CUBE_W'(cube_rnd >>> F);
    v_next    = xyb_pkg::V_W'(cube) + xyb_pkg::V_W'(xyb_pkg::align_bias(bias));
  end

  // intensity scale and lms clamp
  always_comb begin
    prod_sc  = v3 * $signed({1'b0, scale});
    sc_rnd   = (SC_W+1)'(prod_sc) + SC_HALF;
    sc_sh    = sc_rnd >>> xyb_pkg::SCALE_FRAC;
    l_fits   = (&sc_sh[SC_W:xyb_pkg::LMS_W-1]) | ~(|sc_sh[SC_W:xyb_pkg::LMS_W-1]);
    lms_next = l_fits ? sc_sh[xyb_pkg::LMS_W-1:0]
                      : {sc_sh[SC_W], {(xyb_pkg::LMS_W-1){~sc_sh[SC_W]}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1  <= g_next;
      g2  <= g1;
      sq2 <= sq_next;
      v3  <= v_next;
      lms <= lms_next;
    end
  end

endmodule

// ===== design/xyb_mat.sv =====
// one row of the inverse opsin matrix: three products, then sum, round, saturate
// two register stages sharing the pipeline advance; depends on xyb_pkg
module xyb_mat (
  input  logic                          clk,
  input  logic                          adv,
  input  xyb_pkg::lms_t                 lms_l,
  input  xyb_pkg::lms_t                 lms_m,
  input  xyb_pkg::lms_t                 lms_s,
  input  logic [xyb_pkg::REG_W-1:0]     row,
  output xyb_pkg::sample_t              pix
);

  localparam int A_W = xyb_pkg::ACC_W;
  localparam int S_W = xyb_pkg::SAMPLE_WIDTH;
  localparam logic signed [A_W:0] ACC_HALF =
    $signed((A_W+1)'(1) << (xyb_pkg::COEF_FRAC - 1));

  logic signed [xyb_pkg::PROD_W-1:0] prod_l;
  logic signed [xyb_pkg::PROD_W-1:0] prod_m;
  logic signed [xyb_pkg::PROD_W-1:0] prod_s;

  logic signed [A_W:0] acc_rnd;
  logic signed [A_W:0] acc_sh;
  logic                fits;
  xyb_pkg::sample_t    pix_next;

  // sum of products, rounded and saturated to the sample range
  always_comb begin
    acc_rnd  = (A_W+1)'(prod_l) + (A_W+1)'(prod_m) + (A_W+1)'(prod_s) + ACC_HALF;
    acc_sh   = acc_rnd >>> xyb_pkg::COEF_FRAC;
    fits     = (&acc_sh[A_W:S_W-1]) | ~(|acc_sh[A_W:S_W-1]);
    pix_next = fits ? acc_sh[S_W-1:0] : {acc_sh[A_W], {(S_W-1){~acc_sh[A_W]}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_l <= xyb_pkg::field20(row, 0) * lms_l;
      prod_m <= xyb_pkg::field20(row, 1) * lms_m;
      prod_s <= xyb_pkg::field20(row, 2) * lms_s;
      pix    <= pix_next;
    end
  end

endmodule

// ===== design/xyb_to_linear_rgb.sv =====
// Converts one XYB pixel (signed Q4.20) to saturated linear RGB per clock cycle.
// A request is taken into an input register, runs through seven register stages
// (input, gamma clamp, square, cube plus bias, intensity scale, matrix products,
// sum and saturate), the last of which drives the output. Sustained rate is one
// pixel per cycle unless the output stalls: every stage takes a new pixel each
// cycle, and a one-entry skid register at the input holds a request that
// arrives while the output is stalled. Configuration is loaded over the APB
// port at byte address 8*index and must be written while idle.
//
// top level of the converter; depends on xyb_pkg, xyb_cfg, xyb_lms and xyb_mat
module xyb_to_linear_rgb (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  xyb_pkg::sample_t                xyb_x,
  input  xyb_pkg::sample_t                xyb_y,
  input  xyb_pkg::sample_t                xyb_b,
  input  logic                            last_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output xyb_pkg::sample_t                red,
  output xyb_pkg::sample_t                green,
  output xyb_pkg::sample_t                blue,
  output logic                            last_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xyb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [xyb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [xyb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int D  = xyb_pkg::PIPE_DEPTH;
  localparam int SW = xyb_pkg::SAMPLE_WIDTH;

  xyb_pkg::xyb_cfg_t cfg;

  // pipeline control
  logic         adv;
  logic         in_fire;
  logic [D-1:0] vld;
  logic [D-1:0] last_q;

  // input skid register
  logic             skid_vld;
  xyb_pkg::sample_t skid_x;
  xyb_pkg::sample_t skid_y;
  xyb_pkg::sample_t skid_b;
  logic             skid_last;

  // input stage
  xyb_pkg::sample_t x0;
  xyb_pkg::sample_t y0;
  xyb_pkg::sample_t b0;

  logic signed [SW:0] sum_l;
  logic signed [SW:0] sum_m;
  logic signed [SW:0] sum_s;

  xyb_pkg::lms_t lms_l;
  xyb_pkg::lms_t lms_m;
  xyb_pkg::lms_t lms_s;

  assign adv      = ~(vld[D-1] & ~out_ready);
  assign in_ready = ~skid_vld;
  assign in_fire  = in_valid & in_ready;

  // valid bits and last flag follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      skid_vld <= 1'b0;
    end else begin
      if (adv) begin
        vld      <= {vld[D-2:0], skid_vld | in_fire};
        skid_vld <= 1'b0;
      end else if (in_fire) begin
        skid_vld <= 1'b1;
      end
    end
  end

  // payload of the input stage and skid register
  always_ff @(posedge clk) begin
    if (adv) begin
      x0     <= skid_vld ? skid_x : xyb_x;
      y0     <= skid_vld ? skid_y : xyb_y;
      b0     <= skid_vld ? skid_b : xyb_b;
      last_q <= {last_q[D-2:0], skid_vld ? skid_last : last_pixel};
    end
    if (in_fire && !adv) begin
      skid_x    <= xyb_x;
      skid_y    <= xyb_y;
      skid_b    <= xyb_b;
      skid_last <= last_pixel;
    end
  end

  // gamma sums before the cube root bias
  assign sum_l = (SW+1)'(y0) + (SW+1)'(x0);
  assign sum_m = (SW+1)'(y0) - (SW+1)'(x0);
  assign sum_s = (SW+1)'(b0);

  xyb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // lms channels
  xyb_lms u_lms_l (
    .clk    (clk),
    .adv    (adv),
    .sum_in (sum_l),
    .cbrt   (xyb_pkg::field20(cfg.cbrt, 0)),
    .bias   (xyb_pkg::field20(cfg.bias, 0)),
    .scale  (cfg.scale),
    .lms    (lms_l)
  );

  xyb_lms u_lms_m (
    .clk    (clk),
    .adv    (adv),
    .sum_in (sum_m),
    .cbrt   (xyb_pkg::field20(cfg.cbrt, 1)),
    .bias   (xyb_pkg::field20(cfg.bias, 1)),
    .scale  (cfg.scale),
    .lms    (lms_m)
  );

  xyb_lms u_lms_s (
    .clk    (clk),
    .adv    (adv),
    .sum_in (sum_s),
    .cbrt   (xyb_pkg::field20(cfg.cbrt, 2)),
    .bias   (xyb_pkg::field20(cfg.bias, 2)),
    .scale  (cfg.scale),
    .lms    (lms_s)
  );

  // inverse opsin matrix rows
  xyb_mat u_mat_red (
    .clk   (clk),
    .adv   (adv),
    .lms_l (lms_l),
    .lms_m (lms_m),
    .lms_s (lms_s),
    .row   (cfg.mat_red),
    .pix   (red)
  );

  xyb_mat u_mat_green (
    .clk   (clk),
    .adv   (adv),
    .lms_l (lms_l),
    .lms_m (lms_m),
    .lms_s (lms_s),
    .row   (cfg.mat_green),
    .pix   (green)
  );

  xyb_mat u_mat_blue (
    .clk   (clk),
    .adv   (adv),
    .lms_l (lms_l),
    .lms_m (lms_m),
    .lms_s (lms_s),
    .row   (cfg.mat_blue),
    .pix   (blue)
  );

  assign out_valid = vld[D-1];
  assign last_out  = last_q[D-1];

`ifndef SYNTH
  // skid register only fills while the pipeline is stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(!adv))
    else $error("skid register filled while pipeline advanced");

  // a request taken during a stall is parked in the skid register
  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !adv) |=> skid_vld)
    else $error("request taken during stall was not parked");

  // a stalled pipeline keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");
`endif

endmodule
